[rtl/core/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and codes for the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

   typedef enum logic [3:0] {
      ACT_ADD    = 4'd0,
      ACT_SUB    = 4'd1,
      ACT_MUL    = 4'd2,
      ACT_DIV    = 4'd3,
      ACT_GT     = 4'd4,
      ACT_LT     = 4'd5,
      ACT_GE     = 4'd6,
      ACT_LE     = 4'd7,
      ACT_EQ     = 4'd8,
      ACT_NE     = 4'd9,
      ACT_MIN    = 4'd10,
      ACT_MAX    = 4'd11,
      ACT_INC    = 4'd12,
      ACT_DEC    = 4'd13,
      ACT_TO_INT = 4'd14
   } action_type;

   // Which path produces the final value
   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam int DIV_BITS = 32;

   // Payload carried from stage to stage
   typedef struct packed {
      kind_type    kind;
      logic [31:0] res;      // final value for simple operations
      logic        flag;
      logic [1:0]  status;
      logic        neg;      // sign of a product or quotient
      logic        big;      // quotient known to exceed 32 bits
      logic [63:0] mag;      // product, then rounded magnitude
      logic [31:0] rem;      // partial remainder
      logic [31:0] quo;      // quotient bits
      logic [31:0] lo;       // low dividend bits still to shift in
      logic [31:0] divisor;  // divisor magnitude
   } pipe_type;

endpackage

`default_nettype wire

[rtl/core/fpa_front.sv]
// ----------------------------------------------------------------------------
// fpa_front
// Decode, simple operations, multiply, product rounding and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             up_valid,
   output logic                  up_ready,
   input  wire logic [3:0]       action,
   input  wire logic [31:0]      operand_a,
   input  wire logic [31:0]      operand_b,
   output logic                  down_valid,
   input  wire logic             down_ready,
   output fpa_pkg::pipe_type     down_data
);

   localparam logic [32:0] HALF33 = 33'(1) << (FRAC_BITS - 1);
   localparam logic [63:0] HALF64 = 64'(1) << (FRAC_BITS - 1);
   localparam logic [31:0] MAX32  = 32'h7fff_ffff;
   localparam logic [31:0] MIN32  = 32'h8000_0000;

   logic              s1_vld_ff, s2_vld_ff;
   logic              s1_ready, s2_ready;
   fpa_pkg::pipe_type s1_in, s1_ff, s2_in, s2_ff;

   logic signed [32:0] ax, bx, sum, diff, incv, decv, tpos, tneg, tpos_sh, tneg_sh;
   logic signed [63:0] prod;
   logic        [31:0] amag, bmag;
   logic        [63:0] na;
   logic signed [63:0] p;
   logic        [63:0] mr;

   always_comb begin
      ax   = {operand_a[31], operand_a};
      bx   = {operand_b[31], operand_b};
      sum  = ax + bx;
      diff = ax - bx;
      incv = ax + 33'sd1;
      decv = ax - 33'sd1;
      tpos = ax + $signed(HALF33);
      tneg = $signed(HALF33) - ax;
      tpos_sh = tpos >>> FRAC_BITS;
      tneg_sh = tneg >>> FRAC_BITS;
      prod = $signed(operand_a) * $signed(operand_b);
      amag = operand_a[31] ? (32'd0 - operand_a) : operand_a;
      bmag = operand_b[31] ? (32'd0 - operand_b) : operand_b;
      na   = {32'd0, amag} << FRAC_BITS;

      s1_in         = '0;
      s1_in.kind    = fpa_pkg::KIND_SIMPLE;
      s1_in.status  = fpa_pkg::ST_OK;
      s1_in.rem     = na[63:32];
      s1_in.lo      = na[31:0];
      s1_in.divisor = bmag;
      s1_in.mag     = prod;

      case (fpa_pkg::action_type'(action))
         fpa_pkg::ACT_ADD: begin
            if (sum[32] != sum[31]) begin
               s1_in.res    = sum[32] ? MIN32 : MAX32;
               s1_in.status = fpa_pkg::ST_OVF;
            end else begin
               s1_in.res = sum[31:0];
            end
         end
         fpa_pkg::ACT_SUB: begin
            if (diff[32] != diff[31]) begin
               s1_in.res    = diff[32] ? MIN32 : MAX32;
               s1_in.status = fpa_pkg::ST_OVF;
            end else begin
               s1_in.res = diff[31:0];
            end
         end
         fpa_pkg::ACT_MUL: begin
            s1_in.kind = fpa_pkg::KIND_MUL;
         end
         fpa_pkg::ACT_DIV: begin
            if (operand_b == 32'd0) begin
               s1_in.status = fpa_pkg::ST_DIV0;
            end else begin
               s1_in.kind = fpa_pkg::KIND_DIV;
               s1_in.neg  = operand_a[31] ^ operand_b[31];
               s1_in.big  = (na[63:32] >= bmag);
            end
         end
         fpa_pkg::ACT_GT:  s1_in.flag = (ax > bx);
         fpa_pkg::ACT_LT:  s1_in.flag = (ax < bx);
         fpa_pkg::ACT_GE:  s1_in.flag = (ax >= bx);
         fpa_pkg::ACT_LE:  s1_in.flag = (ax <= bx);
         fpa_pkg::ACT_EQ:  s1_in.flag = (ax == bx);
         fpa_pkg::ACT_NE:  s1_in.flag = (ax != bx);
         fpa_pkg::ACT_MIN: s1_in.res  = (ax <= bx) ? operand_a : operand_b;
         fpa_pkg::ACT_MAX: s1_in.res  = (ax >= bx) ? operand_a : operand_b;
         fpa_pkg::ACT_INC: begin
            if (incv[32] != incv[31]) begin
               s1_in.res    = MAX32;
               s1_in.status = fpa_pkg::ST_OVF;
            end else begin
               s1_in.res = incv[31:0];
            end
         end
         fpa_pkg::ACT_DEC: begin
            if (decv[32] != decv[31]) begin
               s1_in.res    = MIN32;
               s1_in.status = fpa_pkg::ST_OVF;
            end else begin
               s1_in.res = decv[31:0];
            end
         end
         fpa_pkg::ACT_TO_INT: begin
            s1_in.res = operand_a[31] ? (32'd0 - tneg_sh[31:0]) : tpos_sh[31:0];
         end
         default: ;
      endcase
   end

   // Round the product magnitude half away from zero
   always_comb begin
      s2_in = s1_ff;
      p     = $signed(s1_ff.mag);
      mr    = p[63] ? (HALF64 - s1_ff.mag) : (s1_ff.mag + HALF64);
      if (s1_ff.kind == fpa_pkg::KIND_MUL) begin
         s2_in.mag = mr >> FRAC_BITS;
         s2_in.neg = p[63];
      end
   end

   assign s2_ready = !s2_vld_ff || down_ready;
   assign s1_ready = !s1_vld_ff || s2_ready;
   assign up_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_vld_ff <= up_valid;
         if (s2_ready) s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= s1_in;
      if (s2_ready) s2_ff <= s2_in;
   end

   assign down_valid = s2_vld_ff;
   assign down_data  = s2_ff;

endmodule

`default_nettype wire

[rtl/core/fpa_div_step.sv]
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring-division stage: resolves one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_step #(
   parameter int BIT_POS = 31
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             up_valid,
   output logic                  up_ready,
   input  wire fpa_pkg::pipe_type up_data,
   output logic                  down_valid,
   input  wire logic             down_ready,
   output fpa_pkg::pipe_type     down_data
);

   logic              vld_ff;
   fpa_pkg::pipe_type data_in, data_ff;
   logic [32:0]       trial, diff;
   logic              ge;

   always_comb begin
      trial   = {up_data.rem, up_data.lo[BIT_POS]};
      diff    = trial - {1'b0, up_data.divisor};
      ge      = (trial >= {1'b0, up_data.divisor});
      data_in = up_data;
      data_in.rem = ge ? diff[31:0] : trial[31:0];
      data_in.quo[BIT_POS] = ge;
   end

   assign up_ready = !vld_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) data_ff <= data_in;
   end

   assign down_valid = vld_ff;
   assign down_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/fpa_back.sv]
// ----------------------------------------------------------------------------
// fpa_back
// Quotient rounding, sign, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             up_valid,
   output logic                  up_ready,
   input  wire fpa_pkg::pipe_type up_data,
   output logic                  down_valid,
   input  wire logic             down_ready,
   output logic [31:0]           result_value,
   output logic                  compare_flag,
   output logic [1:0]            status
);

   localparam logic [63:0] POS_LIM = 64'h0000_0000_7fff_ffff;
   localparam logic [63:0] NEG_LIM = 64'h0000_0000_8000_0000;

   logic              e1_vld_ff, e2_vld_ff, e1_ready, e2_ready;
   fpa_pkg::pipe_type e1_in, e1_ff;
   logic [32:0]       qr;
   logic              ovf;
   logic [31:0]       res_in, res_ff;
   logic              flag_ff;
   logic [1:0]        st_in, st_ff;

   always_comb begin
      e1_in = up_data;
      qr    = {1'b0, up_data.quo} + 33'({up_data.rem, 1'b0} >= {1'b0, up_data.divisor});
      if (up_data.kind == fpa_pkg::KIND_DIV) e1_in.mag = {31'd0, qr};
   end

   always_comb begin
      res_in = e1_ff.res;
      st_in  = e1_ff.status;
      ovf    = e1_ff.big || (e1_ff.neg ? (e1_ff.mag > NEG_LIM) : (e1_ff.mag > POS_LIM));
      if (e1_ff.kind != fpa_pkg::KIND_SIMPLE) begin
         if (ovf) begin
            res_in = e1_ff.neg ? NEG_LIM[31:0] : POS_LIM[31:0];
            st_in  = fpa_pkg::ST_OVF;
         end else begin
            res_in = e1_ff.neg ? (32'd0 - e1_ff.mag[31:0]) : e1_ff.mag[31:0];
         end
      end
   end

   assign e2_ready = !e2_vld_ff || down_ready;
   assign e1_ready = !e1_vld_ff || e2_ready;
   assign up_ready = e1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
      end else begin
         if (e1_ready) e1_vld_ff <= up_valid;
         if (e2_ready) e2_vld_ff <= e1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e1_ready) e1_ff <= e1_in;
      if (e2_ready) begin
         res_ff  <= res_in;
         flag_ff <= e1_ff.flag;
         st_ff   <= st_in;
      end
   end

   assign down_valid   = e2_vld_ff;
   assign result_value = res_ff;
   assign compare_flag = flag_ff;
   assign status       = st_ff;

endmodule

`default_nettype wire

[rtl/core/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_*: req_tuser carries the operation code and
//   req_tdata the two raw operands. Every request yields exactly one
//   response on rsp_*, in request order.
//   From request transfer to rsp_tvalid a request passes two front
//   stages (decode and simple operations with the multiply, then product
//   rounding), 32 restoring-division stages that each resolve one quotient
//   bit, one quotient-rounding stage and the result register. All
//   operations take the same path length.
//   Throughput is one transfer per cycle while rsp_tready stays high; the
//   32-stage divider sets the latency, not the rate.
//   Reset clears every stage valid bit; no response is pending afterwards.
//   When the receiver holds rsp_tready low the result register holds and
//   stages behind it keep filling bubbles until the pipe is full, then
//   req_tready falls. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   input  wire logic [3:0]  req_tuser,   // [3:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [31:0] result_value, [32] compare_flag,
                                         // [34:33] status, [39:35] zero
);

   localparam int NSTEP = fpa_pkg::DIV_BITS;

   fpa_pkg::pipe_type chain_data  [NSTEP+1];
   logic              chain_valid [NSTEP+1];
   logic              chain_ready [NSTEP+1];

   logic [31:0] result_value;
   logic        compare_flag;
   logic [1:0]  status;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .action     (req_tuser),
      .operand_a  (req_tdata[31:0]),
      .operand_b  (req_tdata[63:32]),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_data  (chain_data[0])
   );

   // Quotient bits resolved most significant first
   for (genvar i = 0; i < NSTEP; i++) begin : g_div
      fpa_div_step #(.BIT_POS(NSTEP - 1 - i)) u_step (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_data    (chain_data[i]),
         .down_valid (chain_valid[i+1]),
         .down_ready (chain_ready[i+1]),
         .down_data  (chain_data[i+1])
      );
   end

   fpa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (chain_valid[NSTEP]),
      .up_ready     (chain_ready[NSTEP]),
      .up_data      (chain_data[NSTEP]),
      .down_valid   (rsp_tvalid),
      .down_ready   (rsp_tready),
      .result_value (result_value),
      .compare_flag (compare_flag),
      .status       (status)
   );

   assign rsp_tdata = {5'd0, status, compare_flag, result_value};

endmodule

`default_nettype wire

[bench/fpa_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpa_checker
// Watches both streams of the fixed-point ALU, computes the expected
// response for every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_checker #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   input  wire logic [3:0]  req_tuser,   // [3:0] action
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [31:0] result_value, [32] compare_flag,
                                         // [34:33] status, [39:35] zero
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [31:0] value;
      logic        flag;
      logic [1:0]  status;
   } answer_type;

   answer_type answers[$];

   function automatic longint saturate(input longint v, inout logic [1:0] st);
      if (v > 64'sd2147483647) begin
         st = fpa_pkg::ST_OVF;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         st = fpa_pkg::ST_OVF;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Drop FRAC_BITS, rounding half away from zero
   function automatic longint round_scale(input longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic answer_type alu_answer(input logic [3:0] act,
                                              input logic [31:0] ra,
                                              input logic [31:0] rb);
      longint a, b, r;
      longint unsigned na, nb, q, rm;
      logic [1:0] st;
      logic f;
      a = longint'(signed'(ra));
      b = longint'(signed'(rb));
      r = 0;
      f = 1'b0;
      st = fpa_pkg::ST_OK;
      case (act)
         fpa_pkg::ACT_ADD:    r = saturate(a + b, st);
         fpa_pkg::ACT_SUB:    r = saturate(a - b, st);
         fpa_pkg::ACT_MUL:    r = saturate(round_scale(a * b), st);
         fpa_pkg::ACT_DIV: begin
            if (b == 0) begin
               st = fpa_pkg::ST_DIV0;
            end else begin
               na = ((a < 0) ? -a : a) << FRAC_BITS;
               nb = (b < 0) ? -b : b;
               q = na / nb;
               rm = na % nb;
               if (rm >= nb - rm) q++;
               r = saturate(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), st);
            end
         end
         fpa_pkg::ACT_GT:     f = a > b;
         fpa_pkg::ACT_LT:     f = a < b;
         fpa_pkg::ACT_GE:     f = a >= b;
         fpa_pkg::ACT_LE:     f = a <= b;
         fpa_pkg::ACT_EQ:     f = a == b;
         fpa_pkg::ACT_NE:     f = a != b;
         fpa_pkg::ACT_MIN:    r = (a <= b) ? a : b;
         fpa_pkg::ACT_MAX:    r = (a >= b) ? a : b;
         fpa_pkg::ACT_INC:    r = saturate(a + 1, st);
         fpa_pkg::ACT_DEC:    r = saturate(a - 1, st);
         fpa_pkg::ACT_TO_INT: r = round_scale(a);
         default:             r = 0;
      endcase
      return '{value: r[31:0], flag: f, status: st};
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         errors <= 0;
         pending <= 0;
         answers.delete();
      end else begin
         if (req_tvalid && req_tready)
            answers.push_back(alu_answer(req_tuser, req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            got = '{value: rsp_tdata[31:0], flag: rsp_tdata[32], status: rsp_tdata[34:33]};
            if (answers.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = answers.pop_front();
               if (got !== want || rsp_tdata[39:35] !== 5'd0) begin
                  $display("%0t: mismatch expected value %h flag %b status %0d, got %h %b %0d",
                           $time, want.value, want.flag, want.status,
                           got.value, got.flag, got.status);
                  errors <= errors + 1;
               end
            end
         end
         pending <= answers.size();
      end
   end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operations into the fixed-point ALU with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int RANDOM_ITEMS = 1930;
   localparam int LATENCY      = 36;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   int          errors;
   int          pending;
   bit          sending_done = 1'b0;
   bit          rsp_took = 1'b0;
   int          rsp_wait = 0;

   fixed_point_alu #(.FRAC_BITS(8)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   fpa_checker #(.FRAC_BITS(8)) checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .errors, .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(signed'($urandom_range(0, 1024)) - 512);
         3: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
         4: return 32'($urandom_range(0, 255)) << $urandom_range(0, 24);
         default: return $urandom;
      endcase
   endfunction

   // Present one request after a random gap, hold until transfer
   task automatic send(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= act;
      req_tdata <= {b, a};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_took <= rsp_tvalid && rsp_tready;
   end

   // Draw a fresh wait after every response transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took)
            rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] extremes[6];
      extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                   32'h0000_0100, 32'h0000_0080};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // every operation at the bounds, the unused code and divide by zero
      for (int act = 0; act < 16; act++)
         send(4'(act), extremes[act % 6], extremes[(act + 1) % 6]);
      send(fpa_pkg::ACT_DIV, 32'h0000_0500, 32'h0);
      send(fpa_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(fpa_pkg::ACT_DIV, 32'h8000_0000, 32'h0000_0001);
      send(fpa_pkg::ACT_TO_INT, 32'hFFFF_FF80, 32'h0);
      send(fpa_pkg::ACT_MUL, 32'h0000_0180, 32'hFFFF_FF80);
      for (int n = 0; n < RANDOM_ITEMS; n++)
         send(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      wait (sending_done);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
